// File: rtl/dwct_pkg.sv
// dwct_pkg: shared types and constants for the dna window constraint block
// no dependencies; imported by the interfaces and every rtl module
`default_nettype none

package dwct_pkg;

  // default window length in base-4 digits
  localparam int WINDOW_LEN_DEF = 8;

  // fixed payload widths
  localparam int WIN_FIELD_W = 16;
  localparam int SYM_W       = 2;
  localparam int CFG_W       = 3;
  localparam int RUN_OUT_W   = 4;
  localparam int BAL_OUT_W   = 5;

  // apb port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // limits after reset
  localparam logic [CFG_W-1:0] MAX_RUN_RST = 3'd3;
  localparam logic [CFG_W-1:0] MAX_IMB_RST = 3'd2;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_MAX_RUN = 1'b0,
    REG_MAX_IMB = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_run;
    logic [CFG_W-1:0] max_imbalance;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/dwct_in_if.sv
// dwct_in_if: input channel, window and new symbol with valid/ready
// depends on dwct_pkg for field widths
`default_nettype none

interface dwct_in_if;
  import dwct_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [WIN_FIELD_W-1:0] current_window;
  logic [SYM_W-1:0]       symbol;

  modport source (output valid, output current_window, output symbol, input ready);
  modport sink   (input valid, input current_window, input symbol, output ready);
endinterface

`default_nettype wire

// File: rtl/dwct_out_if.sv
// dwct_out_if: result channel, next window, flags and window statistics
// depends on dwct_pkg for field widths
`default_nettype none

interface dwct_out_if;
  import dwct_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [WIN_FIELD_W-1:0]      next_window;
  logic                        current_ok;
  logic                        next_ok;
  logic [RUN_OUT_W-1:0]        run_length;
  logic signed [BAL_OUT_W-1:0] gc_imbalance;

  modport source (output valid, output next_window, output current_ok, output next_ok,
                  output run_length, output gc_imbalance, input ready);
  modport sink   (input valid, input next_window, input current_ok, input next_ok,
                  input run_length, input gc_imbalance, output ready);
endinterface

`default_nettype wire

// File: rtl/dwct_cfg.sv
// dwct_cfg: apb register file holding the run and balance limits
// depends on dwct_pkg
`default_nettype none

module dwct_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dwct_pkg::PADDR_W-1:0] paddr,
  input  logic [dwct_pkg::PDATA_W-1:0] pwdata,
  output logic [dwct_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output dwct_pkg::cfg_t               cfg
);
  import dwct_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_RUN: cfg_nxt.max_run       = pwdata[CFG_W-1:0];
        REG_MAX_IMB: cfg_nxt.max_imbalance = pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_RUN: prdata = PDATA_W'(cfg_r.max_run);
      REG_MAX_IMB: prdata = PDATA_W'(cfg_r.max_imbalance);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_run       <= MAX_RUN_RST;
      cfg_r.max_imbalance <= MAX_IMB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/dwct_win_eval.sv
// dwct_win_eval: longest run, gc balance and validity of one window
// depends on dwct_pkg; purely combinational
`default_nettype none

module dwct_win_eval #(
  parameter int WINDOW_LEN = dwct_pkg::WINDOW_LEN_DEF,
  localparam int WIN_W = 2 * WINDOW_LEN,
  localparam int RUN_W = $clog2(WINDOW_LEN + 1),
  localparam int BAL_W = RUN_W + 2
) (
  input  logic [WIN_W-1:0]        window,
  input  dwct_pkg::cfg_t          cfg,
  output logic [RUN_W-1:0]        run,
  output logic signed [BAL_W-1:0] bal,
  output logic                    ok
);
  import dwct_pkg::*;

  logic [WINDOW_LEN-1:0] eq;
  logic [WINDOW_LEN-1:0] hi_bits;
  logic [WINDOW_LEN:0]   t;     // t[j]: some run of at least j+1 equal digits
  logic [RUN_W-1:0]      ones;
  logic [BAL_W-1:0]      mag;

  always_comb begin
    eq      = '0;
    hi_bits = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      hi_bits[k] = window[2*k+1];
    end
    for (int k = 1; k < WINDOW_LEN; k++) begin
      eq[k] = (window[2*k +: 2] == window[2*k-2 +: 2]);
    end
  end

  // each threshold is an independent or of ands over consecutive equalities
  always_comb begin
    logic all_eq;
    all_eq = 1'b0;
    t      = '0;
    t[0]   = 1'b1;
    for (int j = 1; j < WINDOW_LEN; j++) begin
      for (int s = 1; s + j <= WINDOW_LEN; s++) begin
        all_eq = 1'b1;
        for (int k = 0; k < j; k++) begin
          all_eq = all_eq & eq[s+k];
        end
        t[j] = t[j] | all_eq;
      end
    end
  end

  // thermometer to binary: only the top set position contributes
  always_comb begin
    run = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if (t[j] && !t[j+1]) begin
        run = run | RUN_W'(j + 1);
      end
    end
  end

  assign ones = RUN_W'($countones(hi_bits));
  assign bal  = $signed({1'b0, ones, 1'b0}) - $signed(BAL_W'(WINDOW_LEN));
  assign mag  = bal[BAL_W-1] ? BAL_W'(-bal) : BAL_W'(bal);

  assign ok = (BAL_W'(run) <= BAL_W'(cfg.max_run))
           && (mag <= BAL_W'(cfg.max_imbalance));

endmodule

`default_nettype wire

// File: rtl/dna_window_constraint_transition.sv
// dna_window_constraint_transition: one entry of the run/gc constraint graph
// an accepted item passes the input register, then the result register
// throughput: one item per cycle while the result side does not stall; both windows
// are checked in parallel between the input register and the result register
// reset: synchronous active low; clears both stage valids, limits go to 3 and 2
// depends on dwct_pkg, dwct_in_if, dwct_out_if, dwct_cfg, dwct_win_eval
`default_nettype none

module dna_window_constraint_transition #(
  parameter int WINDOW_LEN = dwct_pkg::WINDOW_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  dwct_in_if.sink                      in_ch,
  dwct_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dwct_pkg::PADDR_W-1:0] paddr,
  input  logic [dwct_pkg::PDATA_W-1:0] pwdata,
  output logic [dwct_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import dwct_pkg::*;

  localparam int WIN_W = 2 * WINDOW_LEN;
  localparam int RUN_W = $clog2(WINDOW_LEN + 1);
  localparam int BAL_W = RUN_W + 2;

  cfg_t cfg;

  // stage valids and handshakes
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic s1_ready;
  logic in_fire;
  logic s1_move;

  // input register
  logic [WIN_FIELD_W-1:0] s1_win_r;
  logic [SYM_W-1:0]       s1_sym_r;

  // evaluation
  logic [WIN_W-1:0]        cur_w;
  logic [WIN_W-1:0]        nxt_w;
  logic [WIN_FIELD_W-1:0]  nxt_field;
  logic [RUN_W-1:0]        cur_run;
  logic signed [BAL_W-1:0] cur_bal;
  logic                    cur_ok;
  logic [RUN_W-1:0]        nxt_run;
  logic signed [BAL_W-1:0] nxt_bal;
  logic                    nxt_ok;
  logic [7:0]              run8;
  logic signed [7:0]       bal8;
  logic [RUN_OUT_W-1:0]    run_sat;
  logic signed [BAL_OUT_W-1:0] bal_sat;

  // result register
  logic [WIN_FIELD_W-1:0]      res_win_r;
  logic                        res_cok_r;
  logic                        res_nok_r;
  logic [RUN_OUT_W-1:0]        res_run_r;
  logic signed [BAL_OUT_W-1:0] res_bal_r;

  dwct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_ready     = !s1_valid_r || out_free;
  assign in_ch.ready  = s1_ready;
  assign in_fire      = in_ch.valid && s1_ready;
  assign s1_move      = s1_valid_r && out_free;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (out_free ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_free ? s1_valid_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_win_r <= in_ch.current_window;
      s1_sym_r <= in_ch.symbol;
    end
  end

  // digits above the field read as zero, digits above the window are dropped
  always_comb begin
    cur_w     = '0;
    nxt_field = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (i < WIN_FIELD_W) begin
        cur_w[i] = s1_win_r[i];
      end
    end
    nxt_w = {s1_sym_r, cur_w[WIN_W-1:2]};
    for (int i = 0; i < WIN_FIELD_W; i++) begin
      if (i < WIN_W) begin
        nxt_field[i] = nxt_w[i];
      end
    end
  end

  dwct_win_eval #(.WINDOW_LEN(WINDOW_LEN)) u_eval_cur (
    .window (cur_w),
    .cfg    (cfg),
    .run    (cur_run),
    .bal    (cur_bal),
    .ok     (cur_ok)
  );

  dwct_win_eval #(.WINDOW_LEN(WINDOW_LEN)) u_eval_nxt (
    .window (nxt_w),
    .cfg    (cfg),
    .run    (nxt_run),
    .bal    (nxt_bal),
    .ok     (nxt_ok)
  );

  // reported statistics saturate to the field widths
  assign run8 = 8'(cur_run);
  assign bal8 = 8'(cur_bal);
  assign run_sat = (run8 > 8'd15) ? 4'd15 : run8[RUN_OUT_W-1:0];
  assign bal_sat = (bal8 > 8'sd15)  ? 5'sd15 :
                   (bal8 < -8'sd16) ? -5'sd16 : bal8[BAL_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_win_r <= nxt_field;
      res_cok_r <= cur_ok;
      res_nok_r <= cur_ok && nxt_ok;
      res_run_r <= run_sat;
      res_bal_r <= bal_sat;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_window  = res_win_r;
  assign out_ch.current_ok   = res_cok_r;
  assign out_ch.next_ok      = res_nok_r;
  assign out_ch.run_length   = res_run_r;
  assign out_ch.gc_imbalance = res_bal_r;

  // next window can only pass when the current one does
  a_nok_implies_cok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_cok_r || !res_nok_r))
    else $error("next_ok set with current_ok clear");

  // every window has a run of at least one
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_run_r != '0))
    else $error("run_length of zero delivered");

  // a held input item is not dropped while the result side stalls
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_win_r) && $stable(s1_sym_r)))
    else $error("stalled input item lost");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && in_ch.ready))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
